/* sv/tspm_pkg.sv */
// Package with the shared types, constants and codes of the triple store block.
package tspm_pkg;

  localparam int TableDepth = 1024;
  localparam int AddrW = $clog2(TableDepth);
  localparam int FillW = $clog2(TableDepth + 1);

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_TYPE = 3'd1;
  localparam logic [2:0] KIND_SCAN = 3'd2;
  localparam logic [2:0] KIND_JOIN = 3'd3;
  localparam logic [2:0] KIND_KNOWS = 3'd4;

  localparam logic [1:0] REG_LIMIT = 2'd0;
  localparam logic [1:0] REG_TYPE = 2'd1;
  localparam logic [1:0] REG_KNOWS = 2'd2;
  localparam logic [1:0] REG_PERSON = 2'd3;

  typedef struct packed {
    logic [2:0] kind;
    logic [31:0] subject;
    logic [31:0] predicate;
    logic [31:0] object;
    logic [31:0] second_predicate;
  } in_item_t;

  typedef struct packed {
    logic [31:0] match_subject;
    logic [31:0] match_object;
    logic is_last;
    logic [5:0] match_count;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_OUTER_RD, ST_OUTER_EV, ST_IN1_RD, ST_IN1_EV,
    ST_IN2_RD, ST_IN2_EV, ST_EMIT, ST_FINAL
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the accepted transaction
    logic add;        // append the captured triple
    logic rd_outer;   // read the entry at the outer index
    logic rd_inner;   // read the entry at the inner index
    logic clr_inner;  // inner index to zero
    logic inc_inner;
    logic inc_outer;
    logic emit;       // load a match into the output register
    logic final_item; // load the final item into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] kind;
    logic outer_done;  // outer index reached fill or limit reached
    logic inner_done;  // inner index reached fill
    logic outer_pred;  // outer entry satisfies the direct test
    logic inner_hit1;  // inner entry satisfies the first lookup
    logic inner_hit2;  // inner entry satisfies the second lookup
    logic out_busy;
  } stat_t;

endpackage

/* sv/tspm_ctrl.sv */
// Controller state machine that sequences adds, scans and nested lookups.
module tspm_ctrl import tspm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_OUTER_RD;
        end
      end
      ST_OUTER_RD: begin
        if (stat.kind == KIND_ADD) begin
          cmd.add = 1'b1;
          state_nxt = ST_IDLE;
        end else if (stat.kind > KIND_KNOWS) begin
          state_nxt = ST_IDLE;
        end else if (stat.outer_done) begin
          state_nxt = ST_FINAL;
        end else begin
          cmd.rd_outer = 1'b1;
          state_nxt = ST_OUTER_EV;
        end
      end
      ST_OUTER_EV: begin
        if (!stat.outer_pred) begin
          cmd.inc_outer = 1'b1;
          state_nxt = ST_OUTER_RD;
        end else if (stat.kind == KIND_TYPE || stat.kind == KIND_SCAN) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.clr_inner = 1'b1;
          state_nxt = ST_IN1_RD;
        end
      end
      ST_IN1_RD: begin
        if (stat.inner_done) begin
          cmd.inc_outer = 1'b1;
          state_nxt = ST_OUTER_RD;
        end else begin
          cmd.rd_inner = 1'b1;
          state_nxt = ST_IN1_EV;
        end
      end
      ST_IN1_EV: begin
        if (stat.inner_hit1) begin
          cmd.clr_inner = 1'b1;
          if (stat.kind == KIND_JOIN) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_IN2_RD;
          end
        end else begin
          cmd.inc_inner = 1'b1;
          state_nxt = ST_IN1_RD;
        end
      end
      ST_IN2_RD: begin
        if (stat.inner_done) begin
          cmd.inc_outer = 1'b1;
          state_nxt = ST_OUTER_RD;
        end else begin
          cmd.rd_inner = 1'b1;
          state_nxt = ST_IN2_EV;
        end
      end
      ST_IN2_EV: begin
        if (stat.inner_hit2) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.inc_inner = 1'b1;
          state_nxt = ST_IN2_RD;
        end
      end
      ST_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit = 1'b1;
          cmd.inc_outer = 1'b1;
          state_nxt = ST_OUTER_RD;
        end
      end
      ST_FINAL: begin
        if (!stat.out_busy) begin
          cmd.final_item = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* sv/tspm_datapath.sv */
// Datapath with the triple memory, indices, comparators and output register.
module tspm_datapath import tspm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_data,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  logic [95:0] mem [TableDepth];

  in_item_t req_r;
  logic [FillW-1:0] fill_r, outer_r, inner_r;
  logic [5:0] count_r, limit_r;
  logic [31:0] type_r, knows_r, person_r;
  logic [95:0] rd_r, ent_r;
  logic out_valid_r;
  out_item_t out_r;
  logic [31:0] es, ep, eo, is_, ip, io;

  assign {es, ep, eo} = ent_r;
  assign {is_, ip, io} = rd_r;

  always_ff @(posedge clk) begin
    if (cmd.add && fill_r < FillW'(TableDepth)) begin
      mem[fill_r[AddrW-1:0]] <= {req_r.subject, req_r.predicate, req_r.object};
    end
    if (cmd.rd_outer) begin
      ent_r <= mem[outer_r[AddrW-1:0]];
    end else if (cmd.rd_inner) begin
      rd_r <= mem[inner_r[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.clr_inner) begin
      inner_r <= '0;
    end else if (cmd.inc_inner) begin
      inner_r <= inner_r + 1'b1;
    end
    if (cmd.load) begin
      outer_r <= '0;
    end else if (cmd.inc_outer) begin
      outer_r <= outer_r + 1'b1;
    end
    if (cmd.emit) begin
      out_r <= '{match_subject: es,
                 match_object: (req_r.kind == KIND_SCAN) ? eo : 32'd0,
                 is_last: 1'b0, match_count: 6'd0};
    end else if (cmd.final_item) begin
      out_r <= '{match_subject: 32'd0, match_object: 32'd0,
                 is_last: 1'b1, match_count: count_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      count_r <= '0;
      out_valid_r <= 1'b0;
      limit_r <= 6'd63;
      type_r <= 32'd1;
      knows_r <= 32'd3;
      person_r <= 32'd100;
    end else begin
      if (cmd.add && fill_r < FillW'(TableDepth)) begin
        fill_r <= fill_r + 1'b1;
      end
      if (cmd.load) begin
        count_r <= '0;
      end else if (cmd.emit) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.emit || cmd.final_item) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LIMIT: limit_r <= cfg_data[5:0];
          REG_TYPE: type_r <= cfg_data;
          REG_KNOWS: knows_r <= cfg_data;
          REG_PERSON: person_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    stat.kind = req_r.kind;
    stat.outer_done = (outer_r >= fill_r) || (count_r >= limit_r);
    stat.inner_done = inner_r >= fill_r;
    stat.out_busy = out_valid_r && out_stall;
    priority case (req_r.kind)
      KIND_TYPE: stat.outer_pred = (ep == type_r) && (eo == req_r.object);
      KIND_SCAN, KIND_JOIN: stat.outer_pred = (ep == req_r.predicate);
      default: stat.outer_pred = (ep == knows_r);
    endcase
    if (req_r.kind == KIND_JOIN) begin
      stat.inner_hit1 = (is_ == es) && (ip == req_r.second_predicate);
    end else begin
      stat.inner_hit1 = (is_ == es) && (ip == type_r) && (io == person_r);
    end
    stat.inner_hit2 = (is_ == eo) && (ip == type_r) && (io == person_r);
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule

/* sv/triple_store_pattern_match.sv */
// Top level of the triple store with pattern-match queries.
// The input channel carries one transaction per command: an add appends a
// triple, kinds one to four run a query, and unused kinds are dropped.
// An add gives no result. A type query or predicate scan reads the
// filled part of the table one entry at a time and emits each match;
// a join or typed pattern adds one or two nested lookup passes over the
// table for every candidate, so its time grows with the square of the
// fill count. The single-port triple memory gives one read at a time.
// Each query returns its matches in table order up to the result limit,
// then a final transaction with the last flag and the match count.
// One command is worked on at a time; in_stall is high while busy.
// The result channel has one output register; a stall holds the result
// and pauses the query until it is taken.
// Reset empties the table by clearing the fill count and restores the
// configuration registers to their defaults. Configuration must be
// written via cfg_we, cfg_index, cfg_data only while idle; not enforced.
module triple_store_pattern_match import tspm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  tspm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .stat(stat), .cmd(cmd)
  );

  tspm_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

/* bench/tspm_checker.sv */
// Checker that predicts the triple store results and compares each accepted transaction.
`timescale 1ns / 100ps
module tspm_checker import tspm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  logic [31:0] subj_tab [TableDepth];
  logic [31:0] pred_tab [TableDepth];
  logic [31:0] obj_tab [TableDepth];
  int unsigned fill;
  logic [5:0]  limit_reg;
  logic [31:0] type_reg;
  logic [31:0] knows_reg;
  logic [31:0] person_reg;
  out_item_t   match_q[$];

  assign pending = match_q.size();

  function automatic bit has_triple(logic [31:0] s, logic [31:0] p, bit with_obj,
                                    logic [31:0] o);
    for (int j = 0; j < fill; j++) begin
      if (subj_tab[j] == s && pred_tab[j] == p && (!with_obj || obj_tab[j] == o)) return 1;
    end
    return 0;
  endfunction

  task automatic predict_matches(in_item_t it);
    out_item_t r;
    int unsigned cnt;
    bit hit;
    cnt = 0;
    if (it.kind == KIND_ADD) begin
      if (fill < TableDepth) begin
        subj_tab[fill] = it.subject;
        pred_tab[fill] = it.predicate;
        obj_tab[fill] = it.object;
        fill++;
      end
    end else if (it.kind <= KIND_KNOWS) begin
      for (int i = 0; i < fill && cnt < limit_reg; i++) begin
        r = '0;
        r.match_subject = subj_tab[i];
        case (it.kind)
          KIND_TYPE: hit = pred_tab[i] == type_reg && obj_tab[i] == it.object;
          KIND_SCAN: begin
            hit = pred_tab[i] == it.predicate;
            r.match_object = obj_tab[i];
          end
          KIND_JOIN: hit = pred_tab[i] == it.predicate &&
                           has_triple(subj_tab[i], it.second_predicate, 0, '0);
          default: hit = pred_tab[i] == knows_reg &&
                         has_triple(subj_tab[i], type_reg, 1, person_reg) &&
                         has_triple(obj_tab[i], type_reg, 1, person_reg);
        endcase
        if (hit) begin
          match_q.push_back(r);
          cnt++;
        end
      end
      r = '0;
      r.is_last = 1'b1;
      r.match_count = cnt[5:0];
      match_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fill <= 0;
      limit_reg <= 6'd63;
      type_reg <= 32'd1;
      knows_reg <= 32'd3;
      person_reg <= 32'd100;
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LIMIT: limit_reg <= cfg_data[5:0];
          REG_TYPE: type_reg <= cfg_data;
          REG_KNOWS: knows_reg <= cfg_data;
          default: person_reg <= cfg_data;
        endcase
      end
      if (in_valid && !in_stall) predict_matches(in_data);
      if (out_valid && !out_stall) begin
        if (match_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else if (match_q[0].match_subject !== out_data.match_subject ||
                     match_q[0].match_object !== out_data.match_object ||
                     match_q[0].is_last !== out_data.is_last ||
                     match_q[0].match_count !== out_data.match_count) begin
          $display("%0t: mismatch, expected subj %h obj %h last %b cnt %0d, actual subj %h obj %h last %b cnt %0d",
                   $time, match_q[0].match_subject, match_q[0].match_object,
                   match_q[0].is_last, match_q[0].match_count, out_data.match_subject,
                   out_data.match_object, out_data.is_last, out_data.match_count);
          fail_count <= fail_count + 1;
          void'(match_q.pop_front());
        end else begin
          void'(match_q.pop_front());
        end
      end
    end
  end

endmodule

/* bench/triple_store_pattern_match_tb.sv */
// Testbench top that drives commands and configuration into the triple store and reports the verdict.
`timescale 1ns / 100ps
module triple_store_pattern_match_tb;
  import tspm_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  int          stall_mode = 0;
  int          stall_left = 0;
  logic [31:0] cur_type = 32'd1;
  logic [31:0] cur_knows = 32'd3;
  logic [31:0] cur_person = 32'd100;

  always #5 clk = ~clk;

  triple_store_pattern_match dut (.*);

  tspm_checker u_checker (.*);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 300000) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(5, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic send(in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_cmd(logic [2:0] k, logic [31:0] s, logic [31:0] p, logic [31:0] o,
                          logic [31:0] p2);
    in_item_t it;
    it.kind = k;
    it.subject = s;
    it.predicate = p;
    it.object = o;
    it.second_predicate = p2;
    send(it);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    pause(1);
    wait (pending == 0);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TYPE) cur_type = val;
    if (idx == REG_KNOWS) cur_knows = val;
    if (idx == REG_PERSON) cur_person = val;
  endtask

  function automatic logic [31:0] pick_node();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(0, 5);
    if (r < 8) return cur_person;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_pred();
    case ($urandom_range(0, 5))
      0, 1: return cur_type;
      2: return cur_knows;
      3: return 32'd5;
      4: return 32'd6;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t random_cmd();
    in_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) it.kind = KIND_ADD;
    else if (r < 95) it.kind = 3'($urandom_range(1, 4));
    else it.kind = 3'($urandom_range(5, 7));
    it.subject = pick_node();
    it.predicate = pick_pred();
    it.object = ($urandom_range(0, 2) == 0) ? cur_person : pick_node();
    it.second_predicate = pick_pred();
    return it;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      send(random_cmd());
      if ($urandom_range(0, 3) == 0) pause($urandom_range(1, 12));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_cmd(KIND_TYPE, 0, 0, 100, 0);
    send_cmd(KIND_ADD, 1, 1, 100, 0);
    send_cmd(KIND_ADD, 2, 1, 100, 0);
    send_cmd(KIND_ADD, 3, 1, 200, 0);
    send_cmd(KIND_ADD, 1, 3, 2, 0);
    send_cmd(KIND_ADD, 2, 3, 3, 0);
    send_cmd(KIND_ADD, 2, 3, 1, 0);
    send_cmd(KIND_ADD, 1, 5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    pause(3);
    send_cmd(KIND_TYPE, 0, 0, 100, 0);
    send_cmd(KIND_SCAN, 0, 5, 0, 0);
    send_cmd(KIND_SCAN, 0, 32'hFFFF_FFFF, 0, 0);
    send_cmd(KIND_JOIN, 0, 3, 0, 5);
    send_cmd(KIND_JOIN, 0, 1, 0, 3);
    send_cmd(KIND_KNOWS, 0, 0, 0, 0);
    send_cmd(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(3'd5, 0, 0, 0, 0);
    send_cmd(KIND_SCAN, 0, 3, 0, 0);

    write_reg(REG_LIMIT, 32'd63);
    write_reg(REG_TYPE, 32'd1);
    write_reg(REG_KNOWS, 32'd3);
    write_reg(REG_PERSON, 32'd100);
    random_phase(50);

    write_reg(REG_LIMIT, 32'd1);
    write_reg(REG_TYPE, 32'hFFFF_FFFF);
    write_reg(REG_KNOWS, 32'd0);
    write_reg(REG_PERSON, 32'hFFFF_FFFF);
    random_phase(40);

    write_reg(REG_LIMIT, 32'd0);
    random_phase(20);

    write_reg(REG_LIMIT, $urandom_range(2, 8));
    write_reg(REG_TYPE, 32'd1);
    write_reg(REG_KNOWS, 32'd3);
    write_reg(REG_PERSON, 32'd100);
    random_phase(40);

    write_reg(REG_LIMIT, 32'd63);
    send_cmd(KIND_SCAN, 0, 32'd9, 0, 0);
    send_cmd(KIND_TYPE, 0, 0, 100, 0);
    pause(1);

    wait (pending == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* triple_store_pattern_match.f */
sv/tspm_pkg.sv
sv/tspm_ctrl.sv
sv/tspm_datapath.sv
sv/triple_store_pattern_match.sv
bench/tspm_checker.sv
bench/triple_store_pattern_match_tb.sv
